>>> rtl/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared constants, codes and types of the three-class priority queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

    localparam int DEPTH      = 16;
    localparam int NUM_CLASS  = 3;

    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int TOT_W      = $clog2(NUM_CLASS * DEPTH + 1);
    localparam int ADDR_W     = $clog2(NUM_CLASS * DEPTH);

    localparam int DATE_W     = 27;
    localparam int TAG_W      = 32;
    localparam int YEARS_W    = 8;
    localparam int CLASS_W    = 2;
    localparam int OCC_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 27;
    localparam int THR_W      = 22;
    localparam int DIFF_W     = DATE_W + 1;

    localparam int YEAR_SCALE = 10000;

    localparam logic [DATE_W-1:0]  CUR_DATE_RST = DATE_W'(20241018);
    localparam logic [YEARS_W-1:0] ELDER_RST    = YEARS_W'(80);
    localparam logic [YEARS_W-1:0] CHILD_RST    = YEARS_W'(10);

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    localparam logic [CLASS_W-1:0] CLS_ELDER = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_CHILD = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_ADULT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_DATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ELDER_YEARS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHILD_YEARS  = 2'd2;

    typedef struct packed {
        logic              func;
        logic [DATE_W-1:0] birth_date;
        logic [TAG_W-1:0]  tag;
    } t_in_item;

    typedef struct packed {
        logic               has_item;
        logic [DATE_W-1:0]  item_date;
        logic [TAG_W-1:0]   item_tag;
        logic [CLASS_W-1:0] item_class;
        logic               rejected;
        logic [OCC_W-1:0]   occupancy;
    } t_out_item;

    typedef struct packed {
        logic [DATE_W-1:0] date;
        logic [TAG_W-1:0]  tag;
    } t_entry;

    typedef struct packed {
        logic load;
        logic exec;
        logic capture;
    } t_cmd;

    typedef struct packed {
        logic need_read;
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_DONE
    } t_state;

endpackage

>>> rtl/tcpq_ctrl.sv
// ----------------------------------------------------------------------------
// tcpq_ctrl
// Sequencer walking one operation through load, execute, optional read, result.
// ----------------------------------------------------------------------------
module tcpq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  tcpq_pkg::t_status i_status,
    output tcpq_pkg::t_cmd    o_cmd
);
    import tcpq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.need_read ? ST_READ : ST_DONE;
            end
            ST_READ: begin
                o_cmd.capture = 1'b1;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/tcpq_dp.sv
// ----------------------------------------------------------------------------
// tcpq_dp
// Datapath: configuration, age classing, class stores and result register.
// ----------------------------------------------------------------------------
module tcpq_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tcpq_pkg::t_cmd                  i_cmd,
    output tcpq_pkg::t_status               o_status,
    input  tcpq_pkg::t_in_item              i_in_data,
    input  logic                            i_cfg_we,
    input  logic [tcpq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tcpq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output tcpq_pkg::t_out_item             o_out_data
);
    import tcpq_pkg::*;

    localparam logic [THR_W-1:0] ELDER_THR_RST =
        THR_W'((int'(ELDER_RST) + 1) * YEAR_SCALE);
    localparam logic [THR_W-1:0] CHILD_THR_RST = THR_W'(int'(CHILD_RST) * YEAR_SCALE);
    localparam logic signed [DIFF_W-1:0] NEG_YEAR = DIFF_W'(-YEAR_SCALE);

    logic [DATE_W-1:0] r_cur_date;
    logic [THR_W-1:0]  r_elder_thr;
    logic [THR_W-1:0]  r_child_thr;
    logic              r_child_zero;

    logic                     r_func;
    logic [DATE_W-1:0]        r_date;
    logic [TAG_W-1:0]         r_tag;
    logic signed [DIFF_W-1:0] r_diff;

    logic [PTR_W-1:0] r_rptr  [NUM_CLASS];
    logic [PTR_W-1:0] r_wptr  [NUM_CLASS];
    logic [CNT_W-1:0] r_count [NUM_CLASS];
    logic [TOT_W-1:0] r_total;

    t_entry    r_mem [NUM_CLASS*DEPTH];
    t_entry    r_rd_data;
    t_out_item r_res;

    logic               older;
    logic               younger;
    logic [CLASS_W-1:0] enq_cls;
    logic [CLASS_W-1:0] deq_cls;
    logic               deq_found;
    logic [CLASS_W-1:0] sel_cls;
    logic [CNT_W-1:0]   sel_count;
    logic [PTR_W-1:0]   sel_wptr;
    logic [PTR_W-1:0]   sel_rptr;
    logic [PTR_W-1:0]   n_wptr;
    logic [PTR_W-1:0]   n_rptr;
    logic               full;
    logic               do_write;
    logic               do_read;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [TOT_W-1:0]   n_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_date   <= CUR_DATE_RST;
            r_elder_thr  <= ELDER_THR_RST;
            r_child_thr  <= CHILD_THR_RST;
            r_child_zero <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CURRENT_DATE: begin
                    r_cur_date <= i_cfg_data[DATE_W-1:0];
                end
                CFG_ELDER_YEARS: begin
                    r_elder_thr <= THR_W'(THR_W'(i_cfg_data[YEARS_W-1:0])
                                   * THR_W'(YEAR_SCALE) + THR_W'(YEAR_SCALE));
                end
                CFG_CHILD_YEARS: begin
                    r_child_thr  <= THR_W'(THR_W'(i_cfg_data[YEARS_W-1:0])
                                    * THR_W'(YEAR_SCALE));
                    r_child_zero <= (i_cfg_data[YEARS_W-1:0] == '0);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_in_data.func;
            r_date <= i_in_data.birth_date;
            r_tag  <= i_in_data.tag;
            r_diff <= $signed({1'b0, r_cur_date}) - $signed({1'b0, i_in_data.birth_date});
        end
    end

    // The age in whole years is compared through scaled thresholds.
    assign older   = r_diff >= $signed({{(DIFF_W-THR_W){1'b0}}, r_elder_thr});
    assign younger = r_child_zero ? (r_diff <= NEG_YEAR)
                                  : (r_diff < $signed({{(DIFF_W-THR_W){1'b0}}, r_child_thr}));
    assign enq_cls = older ? CLS_ELDER : (younger ? CLS_CHILD : CLS_ADULT);

    always_comb begin
        deq_found = 1'b1;
        if (r_count[0] != '0) begin
            deq_cls = CLS_ELDER;
        end else if (r_count[1] != '0) begin
            deq_cls = CLS_CHILD;
        end else if (r_count[2] != '0) begin
            deq_cls = CLS_ADULT;
        end else begin
            deq_cls   = CLS_ELDER;
            deq_found = 1'b0;
        end
    end

    assign sel_cls   = (r_func == FUNC_ENQ) ? enq_cls : deq_cls;
    assign sel_count = r_count[sel_cls];
    assign sel_wptr  = r_wptr[sel_cls];
    assign sel_rptr  = r_rptr[sel_cls];
    assign n_wptr    = (sel_wptr == PTR_W'(DEPTH - 1)) ? '0 : sel_wptr + 1'b1;
    assign n_rptr    = (sel_rptr == PTR_W'(DEPTH - 1)) ? '0 : sel_rptr + 1'b1;
    assign full      = (sel_count == CNT_W'(DEPTH));
    assign do_write  = (r_func == FUNC_ENQ) && !full;
    assign do_read   = (r_func == FUNC_DEQ) && deq_found;
    assign wr_addr   = ADDR_W'(sel_cls) * ADDR_W'(DEPTH) + ADDR_W'(sel_wptr);
    assign rd_addr   = ADDR_W'(sel_cls) * ADDR_W'(DEPTH) + ADDR_W'(sel_rptr);

    always_comb begin
        n_total = r_total;
        if (do_write) begin
            n_total = r_total + 1'b1;
        end else if (do_read) begin
            n_total = r_total - 1'b1;
        end
    end

    assign o_status.need_read = do_read;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            for (int k = 0; k < NUM_CLASS; k++) begin
                r_rptr[k]  <= '0;
                r_wptr[k]  <= '0;
                r_count[k] <= '0;
            end
        end else if (i_cmd.exec) begin
            r_total <= n_total;
            if (do_write) begin
                r_wptr[sel_cls]  <= n_wptr;
                r_count[sel_cls] <= sel_count + 1'b1;
            end else if (do_read) begin
                r_rptr[sel_cls]  <= n_rptr;
                r_count[sel_cls] <= sel_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && do_write) begin
            r_mem[wr_addr] <= '{date: r_date, tag: r_tag};
        end
        if (i_cmd.exec && do_read) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res.has_item   <= do_read;
            r_res.item_date  <= '0;
            r_res.item_tag   <= '0;
            r_res.item_class <= sel_cls;
            r_res.rejected   <= !(do_write || do_read);
            r_res.occupancy  <= OCC_W'(n_total);
        end else if (i_cmd.capture) begin
            r_res.item_date <= r_rd_data.date;
            r_res.item_tag  <= r_rd_data.tag;
        end
    end

    assign o_out_data = r_res;

    a_total_matches_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total == TOT_W'(r_count[0]) + TOT_W'(r_count[1]) + TOT_W'(r_count[2]))
        else $error("total held differs from the sum of the class counts");

    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count[0] <= CNT_W'(DEPTH)) && (r_count[1] <= CNT_W'(DEPTH))
        && (r_count[2] <= CNT_W'(DEPTH)))
        else $error("class count exceeds the store depth");

    a_read_pops_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && o_status.need_read) |=> (r_total == $past(r_total) - 1'b1))
        else $error("a dequeue did not remove exactly one word");

    a_write_adds_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && do_write) |=> (r_total == $past(r_total) + 1'b1))
        else $error("an enqueue did not add exactly one word");

    a_result_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.exec) |-> !(r_res.has_item && r_res.rejected))
        else $error("result both carries a word and is rejected");

endmodule

>>> rtl/three_class_priority_queue_top.sv
// ----------------------------------------------------------------------------
// three_class_priority_queue_top
// Three-class strict-priority queue with age classing by configured date.
// ----------------------------------------------------------------------------
// Sequence: an accepted word passes through an execute state and, for a dequeue
// that returns an item, a read state (registered read of the class store) before
// its result is valid. The sequencer holds a single operation from acceptance
// until its result is taken, so no new word is accepted before then.
// Reset: queue empty, counts and settings at defaults; store contents are
// undefined and are never read before being written, so no clearing pass runs.
module three_class_priority_queue_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  tcpq_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output tcpq_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [tcpq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tcpq_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tcpq_pkg::*;

    t_cmd    cmd;
    t_status status;

    tcpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tcpq_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_out_data (o_out_data)
    );

endmodule
